/* rtl/slps_pkg.sv */
// shared types, mode codes and pattern timing tables for the status led sequencer
package slps_pkg;

  // widths of state and payload fields
  localparam int MODE_W  = 3;
  localparam int INDEX_W = 4;
  localparam int COUNT_W = 6;

  // transaction opcodes
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_SET  = 1'b1;

  // pattern modes
  localparam logic [MODE_W-1:0] MODE_OFF       = 3'd0;
  localparam logic [MODE_W-1:0] MODE_WINDOW    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_STILL     = 3'd2;
  localparam logic [MODE_W-1:0] MODE_MOVE      = 3'd3;
  localparam logic [MODE_W-1:0] MODE_POINT     = 3'd4;
  localparam logic [MODE_W-1:0] MODE_DONE_OK   = 3'd5;
  localparam logic [MODE_W-1:0] MODE_DONE_FAIL = 3'd6;

  // input transaction payload
  typedef struct packed {
    logic              opcode;
    logic [MODE_W-1:0] new_mode;
  } cmd_t;

  // result transaction payload
  typedef struct packed {
    logic              pin_level;
    logic [MODE_W-1:0] current_mode;
    logic              sequence_done;
  } res_t;

  // pulses in one pass of a pattern, zero for modes without pulses
  function automatic logic [INDEX_W-1:0] pulses_of(input logic [MODE_W-1:0] m);
    logic [INDEX_W-1:0] n;
    unique case (m)
      MODE_WINDOW:    n = 4'd1;
      MODE_MOVE:      n = 4'd3;
      MODE_POINT:     n = 4'd1;
      MODE_DONE_OK:   n = 4'd3;
      MODE_DONE_FAIL: n = 4'd12;
      default:        n = 4'd0;
    endcase
    return n;
  endfunction

  // ticks in the on half of a pulse
  function automatic logic [COUNT_W-1:0] on_ticks(input logic [MODE_W-1:0] m);
    logic [COUNT_W-1:0] t;
    unique case (m)
      MODE_WINDOW:    t = 6'd10;
      MODE_MOVE:      t = 6'd7;
      MODE_POINT:     t = 6'd50;
      MODE_DONE_OK:   t = 6'd30;
      MODE_DONE_FAIL: t = 6'd6;
      default:        t = 6'd0;
    endcase
    return t;
  endfunction

  // ticks in the off half of a pulse; the last move pulse has the long gap
  function automatic logic [COUNT_W-1:0] off_ticks(input logic [MODE_W-1:0]  m,
                                                   input logic [INDEX_W-1:0] idx);
    logic [COUNT_W-1:0] t;
    unique case (m)
      MODE_WINDOW:    t = 6'd10;
      MODE_MOVE:      t = (idx == 4'd2) ? 6'd40 : 6'd7;
      MODE_POINT:     t = 6'd50;
      MODE_DONE_OK:   t = 6'd20;
      MODE_DONE_FAIL: t = 6'd6;
      default:        t = 6'd0;
    endcase
    return t;
  endfunction

endpackage

/* rtl/slps_if.sv */
// valid/ready channel interfaces for command and result transactions
interface slps_in_if;
  logic                      valid;
  logic                      ready;
  logic                      opcode;
  logic [slps_pkg::MODE_W-1:0] new_mode;

  modport source (output valid, output opcode, output new_mode, input ready);
  modport sink   (input valid, input opcode, input new_mode, output ready);
endinterface

interface slps_out_if;
  logic                      valid;
  logic                      ready;
  logic                      pin_level;
  logic [slps_pkg::MODE_W-1:0] current_mode;
  logic                      sequence_done;

  modport source (output valid, output pin_level, output current_mode,
                  output sequence_done, input ready);
  modport sink   (input valid, input pin_level, input current_mode,
                  input sequence_done, output ready);
endinterface

/* rtl/slps_in_reg.sv */
// input register stage that captures command transactions
module slps_in_reg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  slps_pkg::cmd_t       in_cmd,
  output logic                 hold_valid,
  output slps_pkg::cmd_t       hold_cmd,
  input  logic                 hold_take
);

  logic           valid_r;
  logic           valid_nxt;
  slps_pkg::cmd_t cmd_r;

  // accept when empty or when the held transaction moves on this cycle
  assign in_ready  = !valid_r || hold_take;
  assign valid_nxt = (in_valid && in_ready) || (valid_r && !hold_take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r <= in_cmd;
    end
  end

  assign hold_valid = valid_r;
  assign hold_cmd   = cmd_r;

endmodule

/* rtl/slps_pattern.sv */
// pattern state, next-state logic and result register
module slps_pattern (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 active_low,
  input  logic                 cmd_valid,
  input  slps_pkg::cmd_t       cmd,
  output logic                 cmd_take,
  output logic                 res_valid,
  output slps_pkg::res_t       res,
  input  logic                 res_ready
);

  logic [slps_pkg::MODE_W-1:0]  mode_r, mode_nxt;
  logic [slps_pkg::INDEX_W-1:0] pulse_index_r, pulse_index_nxt;
  logic                         in_off_half_r, in_off_half_nxt;
  logic [slps_pkg::COUNT_W-1:0] tick_count_r, tick_count_nxt;
  logic                         res_valid_r;
  slps_pkg::res_t               res_r;
  logic                         done;
  logic                         lit;
  logic [slps_pkg::MODE_W-1:0]  set_mode;
  logic [slps_pkg::INDEX_W-1:0] npulses;
  logic [slps_pkg::INDEX_W-1:0] index_inc;
  logic [slps_pkg::COUNT_W-1:0] count_inc;

  // the result register frees up when empty or drained this cycle
  assign cmd_take = cmd_valid && (!res_valid_r || res_ready);

  // unknown mode codes fall back to off
  assign set_mode  = (cmd.new_mode > slps_pkg::MODE_DONE_FAIL) ? slps_pkg::MODE_OFF
                                                               : cmd.new_mode;
  assign npulses   = slps_pkg::pulses_of(mode_r);
  assign index_inc = pulse_index_r + 4'd1;
  assign count_inc = tick_count_r + 6'd1;

  // next pattern state for one transaction
  always_comb begin
    mode_nxt        = mode_r;
    pulse_index_nxt = pulse_index_r;
    in_off_half_nxt = in_off_half_r;
    tick_count_nxt  = tick_count_r;
    done            = 1'b0;
    if (cmd.opcode == slps_pkg::OP_SET) begin
      if (set_mode != mode_r) begin
        mode_nxt        = set_mode;
        pulse_index_nxt = '0;
        in_off_half_nxt = 1'b0;
        tick_count_nxt  = '0;
      end
    end else if (npulses != '0) begin
      tick_count_nxt = count_inc;
      if (!in_off_half_r) begin
        if (count_inc >= slps_pkg::on_ticks(mode_r)) begin
          in_off_half_nxt = 1'b1;
          tick_count_nxt  = '0;
        end
      end else if (count_inc >= slps_pkg::off_ticks(mode_r, pulse_index_r)) begin
        tick_count_nxt  = '0;
        in_off_half_nxt = 1'b0;
        pulse_index_nxt = index_inc;
        if (index_inc >= npulses) begin
          pulse_index_nxt = '0;
          // one-shot patterns drop back to off
          if (mode_r == slps_pkg::MODE_DONE_OK || mode_r == slps_pkg::MODE_DONE_FAIL) begin
            mode_nxt = slps_pkg::MODE_OFF;
            done     = 1'b1;
          end
        end
      end
    end
  end

  // led drive from the state after this transaction
  always_comb begin
    if (mode_nxt == slps_pkg::MODE_STILL) begin
      lit = 1'b1;
    end else if (slps_pkg::pulses_of(mode_nxt) == '0) begin
      lit = 1'b0;
    end else begin
      lit = !in_off_half_nxt;
    end
  end

  // pattern state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= slps_pkg::MODE_OFF;
      pulse_index_r <= '0;
      in_off_half_r <= 1'b0;
      tick_count_r  <= '0;
    end else if (cmd_take) begin
      mode_r        <= mode_nxt;
      pulse_index_r <= pulse_index_nxt;
      in_off_half_r <= in_off_half_nxt;
      tick_count_r  <= tick_count_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (cmd_take) begin
      res_valid_r <= 1'b1;
    end else if (res_ready) begin
      res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      res_r.pin_level     <= lit ^ active_low;
      res_r.current_mode  <= mode_nxt;
      res_r.sequence_done <= done;
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

  // a finished sequence always reports off
  assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_r && res_r.sequence_done |-> res_r.current_mode == slps_pkg::MODE_OFF)
    else $error("sequence_done without return to off");

  // pulse index stays inside the pattern
  assert property (@(posedge clk) disable iff (!rst_n)
    slps_pkg::pulses_of(mode_r) != '0 |-> pulse_index_r < slps_pkg::pulses_of(mode_r))
    else $error("pulse index beyond pattern length");

  // on-half count never reaches its limit
  assert property (@(posedge clk) disable iff (!rst_n)
    slps_pkg::pulses_of(mode_r) != '0 && !in_off_half_r
      |-> tick_count_r < slps_pkg::on_ticks(mode_r))
    else $error("on-half tick count overrun");

  // a mode command leaves the sanitized mode in force
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd_take && cmd.opcode == slps_pkg::OP_SET |=> mode_r == $past(set_mode))
    else $error("mode command not applied");

  // state moves only with a transaction
  assert property (@(posedge clk) disable iff (!rst_n)
    !cmd_take |=> $stable(mode_r) && $stable(tick_count_r) && $stable(pulse_index_r))
    else $error("pattern state changed without a transaction");

endmodule

/* rtl/status_led_pattern_sequencer_unit.sv */
// Status LED pattern sequencer: each command transaction is either a 10 ms tick or a
// mode change and yields exactly one result transaction with the pin level, the mode
// in force and a one-shot completion flag. One transaction is accepted every cycle;
// it passes an input register and then the result register. While a result waits
// the input register still takes one more transaction; the input stalls only
// when both registers are full and the result is not drained that cycle.
// The cfg_we/cfg_wdata port sets polarity (1 = LED on drives the pin low) and
// should be written only while no transactions are in flight. There is no
// clearing pass after reset.
module status_led_pattern_sequencer_unit (
  input  logic       clk,
  input  logic       rst_n,
  slps_in_if.sink    in_ch,
  slps_out_if.source out_ch,
  input  logic       cfg_we,
  input  logic       cfg_wdata
);

  logic           active_low_r;
  slps_pkg::cmd_t in_cmd;
  logic           hold_valid;
  slps_pkg::cmd_t hold_cmd;
  logic           hold_take;
  slps_pkg::res_t res;

  // polarity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_low_r <= 1'b0;
    end else if (cfg_we) begin
      active_low_r <= cfg_wdata;
    end
  end

  assign in_cmd.opcode   = in_ch.opcode;
  assign in_cmd.new_mode = in_ch.new_mode;

  // input stage
  slps_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_cmd     (in_cmd),
    .hold_valid (hold_valid),
    .hold_cmd   (hold_cmd),
    .hold_take  (hold_take)
  );

  // pattern state and result stage
  slps_pattern u_pattern (
    .clk        (clk),
    .rst_n      (rst_n),
    .active_low (active_low_r),
    .cmd_valid  (hold_valid),
    .cmd        (hold_cmd),
    .cmd_take   (hold_take),
    .res_valid  (out_ch.valid),
    .res        (res),
    .res_ready  (out_ch.ready)
  );

  assign out_ch.pin_level     = res.pin_level;
  assign out_ch.current_mode  = res.current_mode;
  assign out_ch.sequence_done = res.sequence_done;

endmodule

/* tb/sv/status_led_pattern_sequencer_checker.sv */
// checker for the status led sequencer: predicts each result transaction and compares it
module status_led_pattern_sequencer_checker
  import slps_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic              in_opcode,
  input  logic [MODE_W-1:0] in_new_mode,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic              out_pin_level,
  input  logic [MODE_W-1:0] out_current_mode,
  input  logic              out_sequence_done,
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  output int                fail_count,
  output int                results_owed
);

  localparam int REPORT_LIMIT = 10;

  // predicted sequencer state
  logic [MODE_W-1:0]  led_mode;
  logic [INDEX_W-1:0] pulse_num;
  logic               dark_half;
  logic [COUNT_W-1:0] half_ticks;
  logic               polarity_low;

  res_t pending_led_states[$];

  // pulses per pass of the pattern, zero when the mode does not pulse
  function automatic int pulse_total(input logic [MODE_W-1:0] m);
    case (m)
      MODE_WINDOW, MODE_POINT:  return 1;
      MODE_MOVE, MODE_DONE_OK:  return 3;
      MODE_DONE_FAIL:           return 12;
      default:                  return 0;
    endcase
  endfunction

  // length in ticks of the current half of the current pulse
  function automatic int half_length(input logic [MODE_W-1:0]  m,
                                     input logic [INDEX_W-1:0] idx,
                                     input logic               dark);
    case (m)
      MODE_WINDOW:    return 10;
      MODE_MOVE:      return (dark && idx == 2) ? 40 : 7;
      MODE_POINT:     return 50;
      MODE_DONE_OK:   return dark ? 20 : 30;
      MODE_DONE_FAIL: return 6;
      default:        return 0;
    endcase
  endfunction

  // apply one command transaction to the predicted state and return the led state
  function automatic res_t advance_led_pattern(input cmd_t c);
    res_t              r;
    logic [MODE_W-1:0] m;
    logic              lit;
    r.sequence_done = 1'b0;
    if (c.opcode == OP_SET) begin
      // codes past the last mode mean off
      m = (c.new_mode > MODE_DONE_FAIL) ? MODE_OFF : c.new_mode;
      if (m != led_mode) begin
        led_mode   = m;
        pulse_num  = '0;
        dark_half  = 1'b0;
        half_ticks = '0;
      end
    end else if (pulse_total(led_mode) != 0) begin
      half_ticks = half_ticks + 1'b1;
      if (half_ticks >= half_length(led_mode, pulse_num, dark_half)) begin
        half_ticks = '0;
        if (!dark_half) begin
          dark_half = 1'b1;
        end else begin
          dark_half = 1'b0;
          pulse_num = pulse_num + 1'b1;
          if (pulse_num >= pulse_total(led_mode)) begin
            pulse_num = '0;
            // one-shot patterns fall back to off
            if (led_mode == MODE_DONE_OK || led_mode == MODE_DONE_FAIL) begin
              led_mode        = MODE_OFF;
              r.sequence_done = 1'b1;
            end
          end
        end
      end
    end
    lit = (led_mode == MODE_STILL) || (pulse_total(led_mode) != 0 && !dark_half);
    r.pin_level    = lit ^ polarity_low;
    r.current_mode = led_mode;
    return r;
  endfunction

  // watch both channels and the polarity port
  always @(posedge clk) begin
    cmd_t cmd;
    res_t want;
    res_t got;
    if (!rst_n) begin
      led_mode     = MODE_OFF;
      pulse_num    = '0;
      dark_half    = 1'b0;
      half_ticks   = '0;
      polarity_low = 1'b0;
      pending_led_states.delete();
      fail_count   = 0;
    end else begin
      if (cfg_we) begin
        polarity_low = cfg_wdata;
      end

      // compare result transaction with the oldest prediction
      if (out_valid && out_ready) begin
        got.pin_level     = out_pin_level;
        got.current_mode  = out_current_mode;
        got.sequence_done = out_sequence_done;
        if (pending_led_states.size() == 0) begin
          if (fail_count < REPORT_LIMIT) begin
            $display("unexpected result: pin %0b mode %0d done %0b",
                     got.pin_level, got.current_mode, got.sequence_done);
          end
          fail_count++;
        end else begin
          want = pending_led_states.pop_front();
          if (got.pin_level !== want.pin_level ||
              got.current_mode !== want.current_mode ||
              got.sequence_done !== want.sequence_done) begin
            if (fail_count < REPORT_LIMIT) begin
              $display("mismatch: pin %0b/%0b mode %0d/%0d done %0b/%0b (expected/actual)",
                       want.pin_level, got.pin_level, want.current_mode,
                       got.current_mode, want.sequence_done, got.sequence_done);
            end
            fail_count++;
          end
        end
      end

      // predict the result of an accepted command transaction
      if (in_valid && in_ready) begin
        cmd.opcode   = in_opcode;
        cmd.new_mode = in_new_mode;
        pending_led_states.push_back(advance_led_pattern(cmd));
      end
    end
    results_owed = pending_led_states.size();
  end

endmodule

/* tb/sv/status_led_pattern_sequencer_unit_test.sv */
// top of the status led sequencer test: clock, reset, stimulus, watchdog and verdict
module status_led_pattern_sequencer_unit_test;
  import slps_pkg::*;

  localparam logic [MODE_W-1:0] MODE_BAD = 3'd7;
  localparam int STUCK_LIMIT = 3000;
  localparam int PHASE_ITEMS = 212;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;
  logic sink_ready = 1'b0;
  int   gap_pct    = 0;
  int   stall_pct  = 0;
  int   stuck_cycles = 0;
  int   fail_count;
  int   results_owed;

  slps_in_if  in_ch ();
  slps_out_if out_ch ();

  assign out_ch.ready = sink_ready;

  status_led_pattern_sequencer_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  status_led_pattern_sequencer_checker i_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_ch.valid),
    .in_ready          (in_ch.ready),
    .in_opcode         (in_ch.opcode),
    .in_new_mode       (in_ch.new_mode),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_pin_level     (out_ch.pin_level),
    .out_current_mode  (out_ch.current_mode),
    .out_sequence_done (out_ch.sequence_done),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .fail_count        (fail_count),
    .results_owed      (results_owed)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // receiver stalls
  always @(posedge clk) begin
    sink_ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // send one command transaction, with random idle cycles ahead of it
  task automatic send_cmd(input logic op, input logic [MODE_W-1:0] nm);
    while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.opcode   <= op;
    in_ch.new_mode <= nm;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // stop sending and wait until every predicted result has come back
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (results_owed != 0);
    repeat (4) @(posedge clk);
  endtask

  // polarity write while the block is idle
  task automatic set_polarity(input logic value);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // mode pick weighted toward the one-shot and pulsing patterns
  function automatic logic [MODE_W-1:0] pick_mode();
    int roll;
    roll = $urandom_range(9);
    if (roll < 5) begin
      return ($urandom_range(1) == 0) ? MODE_DONE_OK : MODE_DONE_FAIL;
    end else if (roll < 8) begin
      case ($urandom_range(2))
        0:       return MODE_WINDOW;
        1:       return MODE_MOVE;
        default: return MODE_POINT;
      endcase
    end
    return MODE_W'($urandom_range(7));
  endfunction

  // mode set followed by a run of ticks, with the odd stray command mixed in
  task automatic random_phase(input int item_goal);
    int               sent;
    int               ticks;
    logic [MODE_W-1:0] m;
    sent = 0;
    while (sent < item_goal) begin
      m = pick_mode();
      send_cmd(OP_SET, m);
      sent++;
      ticks = ($urandom_range(2) != 0) ? $urandom_range(140, 165) : $urandom_range(1, 60);
      // keep the phase at its item budget
      if (ticks > item_goal - sent) begin
        ticks = item_goal - sent;
      end
      for (int k = 0; k < ticks; k++) begin
        if ($urandom_range(119) == 0) begin
          // either repeat the mode or abort into a random one
          send_cmd(OP_SET, ($urandom_range(1) == 0) ? m : MODE_W'($urandom_range(7)));
        end else begin
          send_cmd(OP_TICK, MODE_W'($urandom_range(7)));
        end
        sent++;
      end
    end
  endtask

  // stimulus and verdict
  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.opcode   = OP_TICK;
    in_ch.new_mode = MODE_OFF;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    set_polarity(1'b0);

    // directed: ticks in off and still, repeats, unknown code, every mode
    send_cmd(OP_TICK, MODE_DONE_OK);
    send_cmd(OP_SET, MODE_STILL);
    send_cmd(OP_TICK, MODE_BAD);
    send_cmd(OP_TICK, MODE_OFF);
    send_cmd(OP_SET, MODE_STILL);
    send_cmd(OP_SET, MODE_BAD);
    send_cmd(OP_SET, MODE_BAD);
    send_cmd(OP_SET, MODE_WINDOW);
    send_cmd(OP_TICK, MODE_OFF);
    send_cmd(OP_TICK, MODE_OFF);
    send_cmd(OP_TICK, MODE_OFF);
    send_cmd(OP_SET, MODE_WINDOW);
    send_cmd(OP_TICK, MODE_OFF);
    send_cmd(OP_SET, MODE_MOVE);
    send_cmd(OP_TICK, MODE_OFF);
    send_cmd(OP_SET, MODE_POINT);
    send_cmd(OP_TICK, MODE_OFF);
    send_cmd(OP_SET, MODE_DONE_OK);
    send_cmd(OP_TICK, MODE_OFF);
    send_cmd(OP_SET, MODE_DONE_FAIL);
    send_cmd(OP_TICK, MODE_OFF);
    send_cmd(OP_SET, MODE_OFF);
    send_cmd(OP_TICK, MODE_OFF);

    // random phases, one idling profile and polarity each
    for (int p = 0; p < 4; p++) begin
      set_polarity(p[0] == 0);
      case (p)
        0: begin
          gap_pct   = 0;
          stall_pct = 0;
        end
        1: begin
          gap_pct   = 79;
          stall_pct = 0;
        end
        2: begin
          gap_pct   = 0;
          stall_pct = 79;
        end
        default: begin
          gap_pct   = 33;
          stall_pct = 33;
        end
      endcase
      random_phase(PHASE_ITEMS);
    end

    drain_results();
    if (fail_count == 0 && results_owed == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
